// ===== sv/asrl_pkg.sv =====
// ----------------------------------------------------------------------------
// asrl_pkg: shared types and constants for the anchor selection block
// Sizes of the ranked cell chain and the word carried down it.
// ----------------------------------------------------------------------------
package asrl_pkg;

  localparam int MAX_SEQS    = 256;
  localparam int MAX_ANCHORS = 32;
  localparam int LEN_BITS    = 16;
  localparam int ID_W        = 8;
  localparam int RANK_W      = 5;
  localparam int CNT_W       = $clog2(MAX_SEQS + 1);
  localparam int AW          = $clog2(MAX_ANCHORS + 1);

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic                ins;
    logic                shl;
    logic [LEN_BITS-1:0] len;
    logic [ID_W-1:0]     id;
  } asrl_ctl_t;

endpackage

// ===== sv/anchor_selection_by_length_rank_top.sv =====
// ----------------------------------------------------------------------------
// anchor_selection_by_length_rank_top: anchor picker over a length-ranked set
// One length word per start; on the word marked last, emits anchor ids.
// ----------------------------------------------------------------------------
// Usage: raise start with a length word while busy is low; every such word is
// taken and slotted straight into a chain of 256 ranked cells
// (longest first, a later arrival ahead of an equal length), so a stream of
// ordinary words runs at one per cycle. The word flagged in_last_seq sets off
// selection: busy rises and the chain drains one rank per cycle towards its
// head, which is read every stride ranks for A anchors, where A is the smaller
// of 32 and the entry count and stride is count/A - at most the entry count.
// Each anchor appears for exactly one cycle with out_valid high; there is no
// back-pressure, so take every strobe. out_last_anchor marks the final one,
// out_overflow says whether any word of the set was dropped because the store
// was full. The store is emptied as the last anchor leaves and start is
// accepted again in that same cycle.
// ----------------------------------------------------------------------------
module anchor_selection_by_length_rank_top
  import asrl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [15:0]       in_seq_length,
  input  logic              in_last_seq,
  output logic              out_valid,
  output logic [ID_W-1:0]   out_anchor_id,
  output logic [RANK_W-1:0] out_anchor_rank,
  output logic              out_last_anchor,
  output logic              out_overflow
);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [AW-1:0]       num_r, num_nxt;
  logic [CNT_W-1:0]    stride_r, stride_nxt;
  logic [CNT_W-1:0]    gap_r, gap_nxt;
  logic [AW-1:0]       emit_r, emit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [RANK_W-1:0]   out_rank_r, out_rank_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic                accept;
  logic                full;
  logic                fin;
  asrl_ctl_t           ctl;
  logic [MAX_SEQS-1:0] occ;
  logic [ID_W-1:0]     head_id;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(MAX_SEQS));
  assign fin    = (emit_r == num_r - AW'(1));

  // Occupancy thermometer: rank k holds a live entry below the count
  for (genvar k = 0; k < MAX_SEQS; k++) begin : g_occ
    assign occ[k] = (CNT_W'(k) < count_r);
  end

  // Insert on accepted words with room; drain one rank per cycle while emitting
  always_comb begin
    ctl.ins = accept && !full;
    ctl.shl = (state_r == S_EMIT);
    ctl.len = in_seq_length[LEN_BITS-1:0];
    ctl.id  = count_r[ID_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    num_nxt       = num_r;
    stride_nxt    = stride_r;
    gap_nxt       = gap_r;
    emit_nxt      = emit_r;
    out_valid_nxt = 1'b0;
    out_id_nxt    = out_id_r;
    out_rank_nxt  = out_rank_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Store if there is room, otherwise drop and flag
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_last_seq) begin
            // Fewer entries than anchors: take every rank
            if (count_nxt < CNT_W'(MAX_ANCHORS)) begin
              num_nxt    = AW'(count_nxt);
              stride_nxt = CNT_W'(1);
            end else begin
              num_nxt    = AW'(MAX_ANCHORS);
              stride_nxt = count_nxt / CNT_W'(MAX_ANCHORS);
            end
            gap_nxt   = '0;
            emit_nxt  = '0;
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (gap_r == '0) begin
          // Head cell holds the rank due now
          out_valid_nxt = 1'b1;
          out_id_nxt    = head_id;
          out_rank_nxt  = emit_r[RANK_W-1:0];
          out_last_nxt  = fin;
          out_ovf_nxt   = ovf_r;
          gap_nxt       = stride_r - CNT_W'(1);
          emit_nxt      = emit_r + AW'(1);
          if (fin) begin
            // Empty the store for the next set
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end else begin
          gap_nxt = gap_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r      <= num_nxt;
    stride_r   <= stride_nxt;
    gap_r      <= gap_nxt;
    emit_r     <= emit_nxt;
    out_id_r   <= out_id_nxt;
    out_rank_r <= out_rank_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  asrl_chain u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .occ     (occ),
    .head_id (head_id)
  );

  assign out_valid       = out_valid_r;
  assign out_anchor_id   = out_id_r;
  assign out_anchor_rank = out_rank_r;
  assign out_last_anchor = out_last_r;
  assign out_overflow    = out_ovf_r;

`ifndef SYNTHESIS
  // Anchors only come out of a selection run
  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("anchor word outside a selection run");

  // The final anchor ends the run
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_anchor |-> !busy)
    else $error("still busy after final anchor");

  // A non-final anchor leaves the run going
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_anchor |-> busy)
    else $error("run ended before final anchor");

  // Entry count never passes capacity
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SEQS))
    else $error("entry count beyond capacity");
`endif

endmodule

// ===== sv/asrl_cell.sv =====
// ----------------------------------------------------------------------------
// asrl_cell: one rank of the sorted chain
// Holds one length and arrival id; takes the new word, the left neighbour's
// word on insertion, or the right neighbour's word while draining.
// ----------------------------------------------------------------------------
module asrl_cell
  import asrl_pkg::*;
(
  input  logic                clk,
  input  asrl_ctl_t           ctl,
  input  logic                occ,
  input  logic                left_take,
  input  logic [LEN_BITS-1:0] left_len,
  input  logic [ID_W-1:0]     left_id,
  input  logic [LEN_BITS-1:0] right_len,
  input  logic [ID_W-1:0]     right_id,
  output logic                take,
  output logic [LEN_BITS-1:0] len_q,
  output logic [ID_W-1:0]     id_q
);

  logic [LEN_BITS-1:0] len_r, len_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;

  // New word belongs here or further left: ties go ahead (higher arrival)
  assign take = !occ || (len_r <= ctl.len);

  always_comb begin
    len_nxt = len_r;
    id_nxt  = id_r;
    if (ctl.shl) begin
      len_nxt = right_len;
      id_nxt  = right_id;
    end else if (ctl.ins && take) begin
      if (left_take) begin
        len_nxt = left_len;
        id_nxt  = left_id;
      end else begin
        len_nxt = ctl.len;
        id_nxt  = ctl.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    id_r  <= id_nxt;
  end

  assign len_q = len_r;
  assign id_q  = id_r;

endmodule

// ===== sv/asrl_chain.sv =====
// ----------------------------------------------------------------------------
// asrl_chain: row of ranked cells
// Wires each cell to its neighbours; rank 0 sits at the head.
// ----------------------------------------------------------------------------
module asrl_chain
  import asrl_pkg::*;
(
  input  logic                clk,
  input  asrl_ctl_t           ctl,
  input  logic [MAX_SEQS-1:0] occ,
  output logic [ID_W-1:0]     head_id
);

  logic [MAX_SEQS-1:0] take;
  logic [LEN_BITS-1:0] len_q [MAX_SEQS];
  logic [ID_W-1:0]     id_q  [MAX_SEQS];

  for (genvar k = 0; k < MAX_SEQS; k++) begin : g_cell
    logic                l_take;
    logic [LEN_BITS-1:0] l_len, r_len;
    logic [ID_W-1:0]     l_id, r_id;

    if (k == 0) begin : g_head
      assign l_take = 1'b0;
      assign l_len  = '0;
      assign l_id   = '0;
    end else begin : g_mid
      assign l_take = take[k-1];
      assign l_len  = len_q[k-1];
      assign l_id   = id_q[k-1];
    end

    if (k == MAX_SEQS - 1) begin : g_tail
      assign r_len = '0;
      assign r_id  = '0;
    end else begin : g_body
      assign r_len = len_q[k+1];
      assign r_id  = id_q[k+1];
    end

    asrl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ[k]),
      .left_take (l_take),
      .left_len  (l_len),
      .left_id   (l_id),
      .right_len (r_len),
      .right_id  (r_id),
      .take      (take[k]),
      .len_q     (len_q[k]),
      .id_q      (id_q[k])
    );
  end

  assign head_id = id_q[0];

endmodule

// ===== verif/anchor_selection_by_length_rank_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// anchor_selection_by_length_rank_top_tb: self-checking bench for anchor picking
// Streams length words in sets closed by a last flag. A local ranked store
// predicts the anchor words of every set. A watcher checks each strobed anchor
// word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module anchor_selection_by_length_rank_top_tb;
  import asrl_pkg::*;

  // One anchor word as it should leave the block
  typedef struct {
    logic [ID_W-1:0]   id;
    logic [RANK_W-1:0] rank;
    logic              last;
    logic              ovf;
  } anchor_t;

  // Directed row: a length word, its last flag and, for tiny sets, the anchor
  // ids in emission order typed in by hand (n_typed of them)
  typedef struct {
    logic [15:0] len;
    logic        last;
    int          n_typed;
    logic [7:0]  id0;
    logic [7:0]  id1;
  } row_t;

  localparam int N_ROWS     = 17;
  localparam int RAND_WORDS = 450;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [15:0]       in_seq_length;
  logic              in_last_seq;
  logic              out_valid;
  logic [ID_W-1:0]   out_anchor_id;
  logic [RANK_W-1:0] out_anchor_rank;
  logic              out_last_anchor;
  logic              out_overflow;

  // Predictor state: the ranked store, its fill level and the drop flag
  logic [15:0]     ranked_len [MAX_SEQS];
  logic [ID_W-1:0] ranked_arrival [MAX_SEQS];
  int unsigned     fill_level;
  bit              dropped_in_set;

  anchor_t pending_anchors [$];
  int      error_count;
  bit      no_gaps;
  row_t    script [N_ROWS];

  anchor_selection_by_length_rank_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_seq_length   (in_seq_length),
    .in_last_seq     (in_last_seq),
    .out_valid       (out_valid),
    .out_anchor_id   (out_anchor_id),
    .out_anchor_rank (out_anchor_rank),
    .out_last_anchor (out_last_anchor),
    .out_overflow    (out_overflow)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    end
  endtask

  // Slot one length into the ranked store; on a last word, work out the
  // anchors and empty the store. Push the anchors only when publish is set.
  task automatic rank_length(input logic [15:0] len, input logic last,
                             input bit publish);
    int unsigned pos;
    int unsigned n_anch;
    int unsigned stride;
    anchor_t     a;
    if (fill_level < MAX_SEQS) begin
      pos = 0;
      // A newcomer carries the highest arrival number, so it goes ahead of
      // every entry that is not strictly longer
      while (pos < fill_level && ranked_len[pos] > len) pos++;
      for (int unsigned k = fill_level; k > pos; k--) begin
        ranked_len[k]     = ranked_len[k-1];
        ranked_arrival[k] = ranked_arrival[k-1];
      end
      ranked_len[pos]     = len;
      ranked_arrival[pos] = fill_level[ID_W-1:0];
      fill_level++;
    end else begin
      // Store full: drop the word, remember it for the whole set
      dropped_in_set = 1'b1;
    end
    if (last) begin
      n_anch = (fill_level < MAX_ANCHORS) ? fill_level : MAX_ANCHORS;
      stride = (n_anch != 0) ? fill_level / n_anch : 0;
      for (int unsigned i = 0; i < n_anch; i++) begin
        a.id   = ranked_arrival[i * stride];
        a.rank = i[RANK_W-1:0];
        a.last = (i + 1 == n_anch);
        a.ovf  = dropped_in_set;
        if (publish) pending_anchors.push_back(a);
      end
      fill_level     = 0;
      dropped_in_set = 1'b0;
    end
  endtask

  // Mostly back to back, now and then a short pause, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // A third of the lengths come from a small pool so that ties are common
  function automatic logic [15:0] pick_length();
    if ($urandom_range(0, 2) != 0) return 16'($urandom);
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'hFFFE;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Present one word from a falling edge and hold it until a rising edge
  // sees start with busy low. Scribble on the data while start is low.
  task automatic send_word(input logic [15:0] len, input logic last);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start         <= 1'b0;
      in_seq_length <= 16'($urandom);
      in_last_seq   <= 1'($urandom);
    end
    @(negedge clk);
    start         <= 1'b1;
    in_seq_length <= len;
    in_last_seq   <= last;
    do @(posedge clk); while (busy);
  endtask

  // Check every strobed anchor word; the block cannot be held off, so
  // sample on each rising edge while out_valid is high
  always @(posedge clk) begin : watch_anchors
    anchor_t want;
    if (rst_n && out_valid) begin
      if (pending_anchors.size() == 0) begin
        report_mismatch($sformatf("unexpected anchor word id %0h rank %0d",
                                  out_anchor_id, out_anchor_rank));
      end else begin
        want = pending_anchors.pop_front();
        compare_field("anchor_id", 16'(out_anchor_id), 16'(want.id));
        compare_field("anchor_rank", 16'(out_anchor_rank), 16'(want.rank));
        compare_field("last_anchor", 16'(out_last_anchor), 16'(want.last));
        compare_field("overflow", 16'(out_overflow), 16'(want.ovf));
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int          set_size;
    int          words_sent;
    int          waited;
    bit          first_set;
    logic [15:0] len;
    logic        last;
    anchor_t     a;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_seq_length  = 16'h0000;
    in_last_seq    = 1'b0;
    fill_level     = 0;
    dropped_in_set = 1'b0;
    error_count    = 0;
    no_gaps        = 1'b0;

    // Directed sets: single words at both length extremes, equal lengths
    // (later arrival first), a longer later word, a longer earlier word,
    // then two mixed sets left to the predictor
    script = '{
      '{16'h0000, 1'b1, 1, 8'd0, 8'd0},
      '{16'hFFFF, 1'b1, 1, 8'd0, 8'd0},
      '{16'h0000, 1'b0, 0, 8'd0, 8'd0},
      '{16'h0000, 1'b1, 2, 8'd1, 8'd0},
      '{16'h0000, 1'b0, 0, 8'd0, 8'd0},
      '{16'hFFFF, 1'b1, 2, 8'd1, 8'd0},
      '{16'hFFFF, 1'b0, 0, 8'd0, 8'd0},
      '{16'h0001, 1'b1, 2, 8'd0, 8'd1},
      '{16'hAAAA, 1'b0, 0, 8'd0, 8'd0},
      '{16'h5555, 1'b0, 0, 8'd0, 8'd0},
      '{16'h5555, 1'b0, 0, 8'd0, 8'd0},
      '{16'h8000, 1'b0, 0, 8'd0, 8'd0},
      '{16'h7FFF, 1'b1, 0, 8'd0, 8'd0},
      '{16'h0100, 1'b0, 0, 8'd0, 8'd0},
      '{16'h00FF, 1'b0, 0, 8'd0, 8'd0},
      '{16'h0100, 1'b0, 0, 8'd0, 8'd0},
      '{16'h0001, 1'b1, 0, 8'd0, 8'd0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the table; hand-typed anchors replace the predicted ones
    for (int r = 0; r < N_ROWS; r++) begin
      send_word(script[r].len, script[r].last);
      rank_length(script[r].len, script[r].last, script[r].n_typed == 0);
      for (int i = 0; i < script[r].n_typed; i++) begin
        a.id   = (i == 0) ? script[r].id0 : script[r].id1;
        a.rank = RANK_W'(i);
        a.last = (i == script[r].n_typed - 1);
        a.ovf  = 1'b0;
        pending_anchors.push_back(a);
      end
    end

    // Random sets. Open with one that overruns the store, so the words past
    // capacity are dropped, the last one included, and the overflow flag
    // rides on every anchor. Then mostly small sets with some wide ones of more
    // than 32 words, whose stride can exceed one.
    words_sent = 0;
    first_set  = 1'b1;
    while (words_sent < RAND_WORDS) begin
      if (first_set) begin
        set_size = $urandom_range(MAX_SEQS + 1, MAX_SEQS + 6);
      end else if ($urandom_range(0, 4) == 0) begin
        set_size = $urandom_range(MAX_ANCHORS + 1, 120);
      end else begin
        set_size = $urandom_range(1, 40);
      end
      // Trim the closing set to the word budget
      if (set_size > RAND_WORDS - words_sent) begin
        set_size = RAND_WORDS - words_sent;
      end
      first_set = 1'b0;
      no_gaps   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < set_size; i++) begin
        len  = pick_length();
        last = (i == set_size - 1);
        send_word(len, last);
        rank_length(len, last, 1'b1);
        words_sent++;
      end
    end

    // Drop start so the final word is not taken twice
    @(negedge clk);
    start <= 1'b0;

    waited = 0;
    while (pending_anchors.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    // Hold for a full emission run to catch stray strobes
    repeat (300) @(posedge clk);
    if (pending_anchors.size() != 0) begin
      report_mismatch($sformatf("%0d anchor words never arrived",
                                pending_anchors.size()));
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
